FILE: sv/pcabs_pkg.sv
// ----------------------------------------------------------------------------
// pcabs_pkg
// Shared types and codes of the path command absolutizer: command opcodes,
// result kinds, curve tracking codes and the request/result records.
// ----------------------------------------------------------------------------
package pcabs_pkg;

    // Fixed widths of the channel fields
    localparam int ARG_WIDTH   = 32;
    localparam int OP_WIDTH    = 4;
    localparam int KIND_WIDTH  = 3;
    localparam int NUM_ARGS    = 6;
    localparam int CURVE_WIDTH = 2;

    // Default internal coordinate width (Q16.16 at 32 bits)
    localparam int COORD_WIDTH = 32;

    // Command opcodes
    localparam logic [OP_WIDTH-1:0] OP_MOVE   = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_LINE   = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_HORIZ  = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_VERT   = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_CUBIC  = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_SCUBIC = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_QUAD   = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_SQUAD  = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_CLOSE  = 4'd8;

    // Result kinds
    localparam logic [KIND_WIDTH-1:0] KIND_MOVE  = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_LINE  = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_CUBIC = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_QUAD  = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_CLOSE = 3'd4;

    // Kind of the previous curve, for smooth reflection
    localparam logic [CURVE_WIDTH-1:0] CURVE_NONE  = 2'd0;
    localparam logic [CURVE_WIDTH-1:0] CURVE_CUBIC = 2'd1;
    localparam logic [CURVE_WIDTH-1:0] CURVE_QUAD  = 2'd2;

    // Control fields of one request
    typedef struct packed {
        logic [OP_WIDTH-1:0] op;
        logic                relative;
        logic                repeat_group;
        logic                new_path;
    } t_cmd;

    // Curve memory and sticky error
    typedef struct packed {
        logic [CURVE_WIDTH-1:0] prev_curve;
        logic                   path_bad;
    } t_track;

    // One absolute result
    typedef struct packed {
        logic [KIND_WIDTH-1:0]       kind;
        logic signed [ARG_WIDTH-1:0] ctrl1_x;
        logic signed [ARG_WIDTH-1:0] ctrl1_y;
        logic signed [ARG_WIDTH-1:0] ctrl2_x;
        logic signed [ARG_WIDTH-1:0] ctrl2_y;
        logic signed [ARG_WIDTH-1:0] end_x;
        logic signed [ARG_WIDTH-1:0] end_y;
        logic                        path_error;
    } t_result;

endpackage

FILE: sv/pcabs_core.sv
// ----------------------------------------------------------------------------
// pcabs_core
// Combinational step of the absolutizer: turns one registered request and
// the current pen/control/start state into an absolute result and the next
// state. All sums saturate to the signed CW-bit coordinate range.
// ----------------------------------------------------------------------------
module pcabs_core #(
    parameter int CW = pcabs_pkg::COORD_WIDTH
) (
    input  pcabs_pkg::t_cmd                        i_cmd,
    input  logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_args [pcabs_pkg::NUM_ARGS],
    input  logic signed [CW-1:0]                   i_pen_x,
    input  logic signed [CW-1:0]                   i_pen_y,
    input  logic signed [CW-1:0]                   i_ctrl_x,
    input  logic signed [CW-1:0]                   i_ctrl_y,
    input  logic signed [CW-1:0]                   i_start_x,
    input  logic signed [CW-1:0]                   i_start_y,
    input  pcabs_pkg::t_track                      i_trk,
    input  logic                                   i_awaiting,
    output logic signed [CW-1:0]                   o_pen_x,
    output logic signed [CW-1:0]                   o_pen_y,
    output logic signed [CW-1:0]                   o_ctrl_x,
    output logic signed [CW-1:0]                   o_ctrl_y,
    output logic signed [CW-1:0]                   o_start_x,
    output logic signed [CW-1:0]                   o_start_y,
    output pcabs_pkg::t_track                      o_trk,
    output pcabs_pkg::t_result                     o_res
);

    localparam int AW = pcabs_pkg::ARG_WIDTH;
    localparam int XW = (CW > AW) ? CW : AW;
    localparam logic signed [XW-1:0] X_MAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [XW-1:0] X_MIN = ~X_MAX;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = ~C_MAX;

    // Clamp a 32-bit argument into the coordinate range
    function automatic logic signed [CW-1:0] take(input logic signed [AW-1:0] raw);
        logic signed [XW-1:0] ext;
        logic signed [XW-1:0] lim;
        begin
            ext = XW'(raw);
            if (ext > X_MAX) begin
                lim = X_MAX;
            end else if (ext < X_MIN) begin
                lim = X_MIN;
            end else begin
                lim = ext;
            end
            return lim[CW-1:0];
        end
    endfunction

    function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        begin
            s = {a[CW-1], a} + {b[CW-1], b};
            if (s[CW] != s[CW-1]) begin
                return s[CW] ? C_MIN : C_MAX;
            end
            return s[CW-1:0];
        end
    endfunction

    function automatic logic signed [CW-1:0] sat_sub(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        begin
            s = {a[CW-1], a} - {b[CW-1], b};
            if (s[CW] != s[CW-1]) begin
                return s[CW] ? C_MIN : C_MAX;
            end
            return s[CW-1:0];
        end
    endfunction

    // Low 32 bits of the sign-extended coordinate
    function automatic logic signed [AW-1:0] give(input logic signed [CW-1:0] v);
        logic signed [XW-1:0] ext;
        begin
            ext = XW'(v);
            return ext[AW-1:0];
        end
    endfunction

    logic signed [CW-1:0]  b_pen_x, b_pen_y, b_ctrl_x, b_ctrl_y, b_start_x, b_start_y;
    logic [pcabs_pkg::CURVE_WIDTH-1:0] b_prev;
    logic                  b_bad;
    logic                  first;
    logic signed [CW-1:0]  a [pcabs_pkg::NUM_ARGS];
    logic signed [CW-1:0]  base0;
    logic signed [CW-1:0]  refl_x, refl_y;
    logic                  use_refl;
    logic signed [CW-1:0]  c1x, c1y, c2x, c2y, ex, ey;
    logic [pcabs_pkg::KIND_WIDTH-1:0] kind;
    logic                  known;

    // Clear the state view on a new path
    always_comb begin
        if (i_cmd.new_path) begin
            b_pen_x   = '0;
            b_pen_y   = '0;
            b_ctrl_x  = '0;
            b_ctrl_y  = '0;
            b_start_x = '0;
            b_start_y = '0;
            b_prev    = pcabs_pkg::CURVE_NONE;
            b_bad     = 1'b0;
        end else begin
            b_pen_x   = i_pen_x;
            b_pen_y   = i_pen_y;
            b_ctrl_x  = i_ctrl_x;
            b_ctrl_y  = i_ctrl_y;
            b_start_x = i_start_x;
            b_start_y = i_start_y;
            b_prev    = i_trk.prev_curve;
            b_bad     = i_trk.path_bad;
        end
    end

    assign first = i_cmd.new_path | i_awaiting;

    // Make arguments absolute; the first one of V offsets from pen y
    assign base0 = (i_cmd.op == pcabs_pkg::OP_VERT) ? b_pen_y : b_pen_x;

    always_comb begin
        for (int i = 0; i < pcabs_pkg::NUM_ARGS; i++) begin
            if (!i_cmd.relative) begin
                a[i] = take(i_args[i]);
            end else if (i == 0) begin
                a[i] = sat_add(take(i_args[i]), base0);
            end else begin
                a[i] = sat_add(take(i_args[i]), (i % 2 == 1) ? b_pen_y : b_pen_x);
            end
        end
    end

    // Reflect the previous control point through the pen point
    assign refl_x = sat_sub(sat_add(b_pen_x, b_pen_x), b_ctrl_x);
    assign refl_y = sat_sub(sat_add(b_pen_y, b_pen_y), b_ctrl_y);
    assign use_refl = ((i_cmd.op == pcabs_pkg::OP_SCUBIC) && (b_prev == pcabs_pkg::CURVE_CUBIC))
                   || ((i_cmd.op == pcabs_pkg::OP_SQUAD) && (b_prev == pcabs_pkg::CURVE_QUAD));

    // Decode the command
    always_comb begin
        c1x   = '0;
        c1y   = '0;
        c2x   = '0;
        c2y   = '0;
        ex    = b_pen_x;
        ey    = b_pen_y;
        kind  = pcabs_pkg::KIND_LINE;
        known = 1'b1;
        case (i_cmd.op)
            pcabs_pkg::OP_MOVE, pcabs_pkg::OP_LINE: begin
                kind = ((i_cmd.op == pcabs_pkg::OP_MOVE) && !i_cmd.repeat_group)
                     ? pcabs_pkg::KIND_MOVE : pcabs_pkg::KIND_LINE;
                ex = a[0];
                ey = a[1];
            end
            pcabs_pkg::OP_HORIZ: begin
                ex = a[0];
            end
            pcabs_pkg::OP_VERT: begin
                ey = a[0];
            end
            pcabs_pkg::OP_CUBIC: begin
                kind = pcabs_pkg::KIND_CUBIC;
                c1x = a[0];
                c1y = a[1];
                c2x = a[2];
                c2y = a[3];
                ex  = a[4];
                ey  = a[5];
            end
            pcabs_pkg::OP_SCUBIC: begin
                kind = pcabs_pkg::KIND_CUBIC;
                c1x = use_refl ? refl_x : b_pen_x;
                c1y = use_refl ? refl_y : b_pen_y;
                c2x = a[0];
                c2y = a[1];
                ex  = a[2];
                ey  = a[3];
            end
            pcabs_pkg::OP_QUAD: begin
                kind = pcabs_pkg::KIND_QUAD;
                c1x = a[0];
                c1y = a[1];
                ex  = a[2];
                ey  = a[3];
            end
            pcabs_pkg::OP_SQUAD: begin
                kind = pcabs_pkg::KIND_QUAD;
                c1x = use_refl ? refl_x : b_pen_x;
                c1y = use_refl ? refl_y : b_pen_y;
                ex  = a[0];
                ey  = a[1];
            end
            pcabs_pkg::OP_CLOSE: begin
                kind = pcabs_pkg::KIND_CLOSE;
                ex = b_start_x;
                ey = b_start_y;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Advance the state; an unknown command leaves pen, control, start and curve memory as they were but sets the error
    always_comb begin
        o_pen_x        = b_pen_x;
        o_pen_y        = b_pen_y;
        o_ctrl_x       = b_ctrl_x;
        o_ctrl_y       = b_ctrl_y;
        o_start_x      = b_start_x;
        o_start_y      = b_start_y;
        o_trk.prev_curve = b_prev;
        if (known) begin
            o_pen_x = ex;
            o_pen_y = ey;
            if (kind == pcabs_pkg::KIND_CUBIC) begin
                o_ctrl_x = c2x;
                o_ctrl_y = c2y;
                o_trk.prev_curve = pcabs_pkg::CURVE_CUBIC;
            end else if (kind == pcabs_pkg::KIND_QUAD) begin
                o_ctrl_x = c1x;
                o_ctrl_y = c1y;
                o_trk.prev_curve = pcabs_pkg::CURVE_QUAD;
            end else begin
                o_ctrl_x = ex;
                o_ctrl_y = ey;
                o_trk.prev_curve = pcabs_pkg::CURVE_NONE;
            end
            if (kind == pcabs_pkg::KIND_MOVE) begin
                o_start_x = ex;
                o_start_y = ey;
            end
        end
        o_trk.path_bad = b_bad | ~known | (first & (kind != pcabs_pkg::KIND_MOVE));
    end

    // Pack the result
    always_comb begin
        o_res.kind       = kind;
        o_res.ctrl1_x    = give(c1x);
        o_res.ctrl1_y    = give(c1y);
        o_res.ctrl2_x    = give(c2x);
        o_res.ctrl2_y    = give(c2y);
        o_res.end_x      = give(ex);
        o_res.end_y      = give(ey);
        o_res.path_error = o_trk.path_bad;
    end

endmodule

FILE: sv/pcabs_out_reg.sv
// ----------------------------------------------------------------------------
// pcabs_out_reg
// Result register of the absolutizer: holds one finished result until the
// receiver takes it and tells the upstream stage when it may load.
// ----------------------------------------------------------------------------
module pcabs_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  pcabs_pkg::t_result i_res,
    input  logic               i_stall,
    output logic               o_ready,
    output logic               o_valid,
    output pcabs_pkg::t_result o_res
);

    logic               r_vld;
    logic               n_vld;
    pcabs_pkg::t_result r_res;

    // Free when empty or when the held result leaves this cycle
    assign o_ready = ~r_vld | ~i_stall;

    assign n_vld = i_load | (r_vld & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

FILE: sv/path_command_absolutizer.sv
// ----------------------------------------------------------------------------
// path_command_absolutizer
// Turns tokenized vector path commands into absolute moveto, lineto, cubic,
// quadratic and closepath results, tracking pen, control and subpath start.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with command fields i_op, i_relative,
//   i_repeat_group, i_new_path and six Q16.16 arguments. A request is taken
//   at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with one absolute result per request,
//   taken at an edge with o_valid high and i_stall low.
//   A taken request passes through the input register, then the result
//   register. Throughput: one request per cycle while the receiver does not
//   stall. The pen/control state update of one request is combinational
//   saturating adds and muxes between the input register and the result
//   register, so the next request uses it right away.
//   Reset (synchronous, active low): both stages empty, pen, control and
//   subpath start at zero, no curve memory, error clear, and the next
//   request counts as the first one of a path.
//   Receiver stall: the result register holds its result; the input
//   register still takes one more request, then o_stall rises until the
//   result leaves.
// ----------------------------------------------------------------------------
module path_command_absolutizer #(
    parameter int COORD_WIDTH = pcabs_pkg::COORD_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [pcabs_pkg::OP_WIDTH-1:0]         i_op,
    input  logic                                   i_relative,
    input  logic                                   i_repeat_group,
    input  logic                                   i_new_path,
    input  logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg0,
    input  logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg1,
    input  logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg2,
    input  logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg3,
    input  logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg4,
    input  logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg5,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [pcabs_pkg::KIND_WIDTH-1:0]       o_out_kind,
    output logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_ctrl1_x,
    output logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_ctrl1_y,
    output logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_ctrl2_x,
    output logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_ctrl2_y,
    output logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_end_x,
    output logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_end_y,
    output logic                                   o_path_error
);

    localparam int CW = COORD_WIDTH;

    // Input register
    logic                                   r_in_vld;
    pcabs_pkg::t_cmd                        r_in_cmd;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] r_in_arg [pcabs_pkg::NUM_ARGS];

    // Path state
    logic signed [CW-1:0] r_pen_x, r_pen_y, r_ctrl_x, r_ctrl_y, r_start_x, r_start_y;
    pcabs_pkg::t_track    r_trk;
    logic                 r_awaiting;

    logic signed [CW-1:0] n_pen_x, n_pen_y, n_ctrl_x, n_ctrl_y, n_start_x, n_start_y;
    pcabs_pkg::t_track    n_trk;
    logic                 n_in_vld;

    pcabs_pkg::t_result   core_res;
    pcabs_pkg::t_result   out_res;
    logic                 out_ready;
    logic                 adv;
    logic                 in_load;

    // Handshake: advance when the result register is free
    assign adv      = r_in_vld & out_ready;
    assign o_stall  = r_in_vld & ~out_ready;
    assign in_load  = i_valid & ~o_stall;
    assign n_in_vld = in_load | (r_in_vld & ~adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_cmd.op           <= i_op;
            r_in_cmd.relative     <= i_relative;
            r_in_cmd.repeat_group <= i_repeat_group;
            r_in_cmd.new_path     <= i_new_path;
            r_in_arg[0]           <= i_arg0;
            r_in_arg[1]           <= i_arg1;
            r_in_arg[2]           <= i_arg2;
            r_in_arg[3]           <= i_arg3;
            r_in_arg[4]           <= i_arg4;
            r_in_arg[5]           <= i_arg5;
        end
    end

    pcabs_core #(
        .CW (CW)
    ) u_core (
        .i_cmd      (r_in_cmd),
        .i_args     (r_in_arg),
        .i_pen_x    (r_pen_x),
        .i_pen_y    (r_pen_y),
        .i_ctrl_x   (r_ctrl_x),
        .i_ctrl_y   (r_ctrl_y),
        .i_start_x  (r_start_x),
        .i_start_y  (r_start_y),
        .i_trk      (r_trk),
        .i_awaiting (r_awaiting),
        .o_pen_x    (n_pen_x),
        .o_pen_y    (n_pen_y),
        .o_ctrl_x   (n_ctrl_x),
        .o_ctrl_y   (n_ctrl_y),
        .o_start_x  (n_start_x),
        .o_start_y  (n_start_y),
        .o_trk      (n_trk),
        .o_res      (core_res)
    );

    // Update path state as each request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x    <= '0;
            r_pen_y    <= '0;
            r_ctrl_x   <= '0;
            r_ctrl_y   <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_trk      <= '{prev_curve: pcabs_pkg::CURVE_NONE, path_bad: 1'b0};
            r_awaiting <= 1'b1;
        end else if (adv) begin
            r_pen_x    <= n_pen_x;
            r_pen_y    <= n_pen_y;
            r_ctrl_x   <= n_ctrl_x;
            r_ctrl_y   <= n_ctrl_y;
            r_start_x  <= n_start_x;
            r_start_y  <= n_start_y;
            r_trk      <= n_trk;
            r_awaiting <= 1'b0;
        end
    end

    pcabs_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (core_res),
        .i_stall (i_stall),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_out_kind   = out_res.kind;
    assign o_ctrl1_x    = out_res.ctrl1_x;
    assign o_ctrl1_y    = out_res.ctrl1_y;
    assign o_ctrl2_x    = out_res.ctrl2_x;
    assign o_ctrl2_y    = out_res.ctrl2_y;
    assign o_end_x      = out_res.end_x;
    assign o_end_y      = out_res.end_y;
    assign o_path_error = out_res.path_error;

    // Stall only with both stages full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_vld && o_valid))
        else $error("input stalled while a stage is free");

    // Closepath returns the pen to the subpath start
    a_close_pen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_in_cmd.op == pcabs_pkg::OP_CLOSE) && !r_in_cmd.new_path)
        |=> ((r_pen_x == $past(r_start_x)) && (r_pen_y == $past(r_start_y))))
        else $error("closepath did not return pen to subpath start");

    // A plain moveto opens a subpath at the new pen point
    a_move_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_in_cmd.op == pcabs_pkg::OP_MOVE) && !r_in_cmd.repeat_group)
        |=> ((r_start_x == r_pen_x) && (r_start_y == r_pen_y)))
        else $error("moveto did not set subpath start");

    // An unknown command sets the sticky error
    a_unknown_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_in_cmd.op > pcabs_pkg::OP_CLOSE)) |=> r_trk.path_bad)
        else $error("unknown command left error clear");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for path_command_absolutizer. A queue of path commands
// (a directed opening, then random well-formed paths mixed with broken ones
// and unknown opcodes) feeds a clocked driver; a clocked monitor compares
// every result against a local predictor of pen, control and subpath state.
// ----------------------------------------------------------------------------
module tb;

    localparam int          ITEM_COUNT  = 1850;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          SETTLE      = 20;
    localparam logic [31:0] Q_ONE       = 32'h0001_0000;
    localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN       = 32'h8000_0000;
    localparam longint      COORD_MAX   =
        (longint'(1) <<< (pcabs_pkg::COORD_WIDTH - 1)) - 1;
    localparam longint      COORD_MIN   = -COORD_MAX - 1;

    // One queued path command plus its send timing
    typedef struct {
        pcabs_pkg::t_cmd                                        cmd;
        logic [pcabs_pkg::NUM_ARGS-1:0][pcabs_pkg::ARG_WIDTH-1:0] arg;
        int unsigned                                            gap;
        bit                                                     drain;
    } t_path_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [pcabs_pkg::OP_WIDTH-1:0] i_op = pcabs_pkg::OP_MOVE;
    logic i_relative = 1'b0;
    logic i_repeat_group = 1'b0;
    logic i_new_path = 1'b0;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg0 = '0;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg1 = '0;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg2 = '0;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg3 = '0;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg4 = '0;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] i_arg5 = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [pcabs_pkg::KIND_WIDTH-1:0] o_out_kind;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_ctrl1_x;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_ctrl1_y;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_ctrl2_x;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_ctrl2_y;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_end_x;
    logic signed [pcabs_pkg::ARG_WIDTH-1:0] o_end_y;
    logic o_path_error;

    t_path_req           cmd_q[$];
    pcabs_pkg::t_result  expected_abs_q[$];
    t_path_req           on_bus;
    int          taken_cnt = 0;
    int          done_cnt = 0;
    int          items_total = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int unsigned gap_left = 0;
    bit          gap_armed = 1'b0;
    bit          send_busy = 1'b1;
    bit          hold_next = 1'b0;
    bit          recv_busy = 1'b1;
    int unsigned stall_left = 0;
    int unsigned stall_phase = 0;

    // Predicted block state
    longint             pos_x = 0, pos_y = 0;
    longint             ctl_x = 0, ctl_y = 0;
    longint             sub_x = 0, sub_y = 0;
    logic               err_sticky = 1'b0;
    logic [pcabs_pkg::CURVE_WIDTH-1:0] last_curve = pcabs_pkg::CURVE_NONE;
    bit                 at_path_start = 1'b1;

    path_command_absolutizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_relative     (i_relative),
        .i_repeat_group (i_repeat_group),
        .i_new_path     (i_new_path),
        .i_arg0         (i_arg0),
        .i_arg1         (i_arg1),
        .i_arg2         (i_arg2),
        .i_arg3         (i_arg3),
        .i_arg4         (i_arg4),
        .i_arg5         (i_arg5),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_kind     (o_out_kind),
        .o_ctrl1_x      (o_ctrl1_x),
        .o_ctrl1_y      (o_ctrl1_y),
        .o_ctrl2_x      (o_ctrl2_x),
        .o_ctrl2_y      (o_ctrl2_y),
        .o_end_x        (o_end_x),
        .o_end_y        (o_end_y),
        .o_path_error   (o_path_error)
    );

    // Saturating coordinate arithmetic
    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint sat_add(longint a, longint b);
        return clamp_coord(a + b);
    endfunction

    // Mirror a control point through the pen point
    function automatic longint mirror(longint p, longint c);
        return clamp_coord(clamp_coord(2 * p) - c);
    endfunction

    // Advance the predicted state by one request and return its absolute result
    function automatic pcabs_pkg::t_result absolutize(t_path_req r);
        longint                           a [pcabs_pkg::NUM_ARGS];
        longint                           c1x, c1y, c2x, c2y, ex, ey;
        logic [pcabs_pkg::KIND_WIDTH-1:0] kind;
        bit                               first;
        int                               i;
        pcabs_pkg::t_result               res;
        c1x = 0;
        c1y = 0;
        c2x = 0;
        c2y = 0;
        if (r.cmd.new_path) begin
            pos_x = 0;
            pos_y = 0;
            ctl_x = 0;
            ctl_y = 0;
            sub_x = 0;
            sub_y = 0;
            err_sticky = 1'b0;
            last_curve = pcabs_pkg::CURVE_NONE;
        end
        first = r.cmd.new_path || at_path_start;
        at_path_start = 1'b0;

        // Offsets go from the pen point as it was before this request
        for (i = 0; i < pcabs_pkg::NUM_ARGS; i++) begin
            a[i] = clamp_coord(longint'($signed(r.arg[i])));
            if (r.cmd.relative && r.cmd.op != pcabs_pkg::OP_HORIZ
                && r.cmd.op != pcabs_pkg::OP_VERT)
                a[i] = sat_add(a[i], (i % 2 == 1) ? pos_y : pos_x);
        end
        if (r.cmd.relative && r.cmd.op == pcabs_pkg::OP_HORIZ) a[0] = sat_add(a[0], pos_x);
        if (r.cmd.relative && r.cmd.op == pcabs_pkg::OP_VERT) a[0] = sat_add(a[0], pos_y);

        ex = pos_x;
        ey = pos_y;
        case (r.cmd.op)
            pcabs_pkg::OP_MOVE, pcabs_pkg::OP_LINE: begin
                kind = (r.cmd.op == pcabs_pkg::OP_MOVE && !r.cmd.repeat_group)
                     ? pcabs_pkg::KIND_MOVE : pcabs_pkg::KIND_LINE;
                ex = a[0];
                ey = a[1];
            end
            pcabs_pkg::OP_HORIZ: begin
                kind = pcabs_pkg::KIND_LINE;
                ex = a[0];
            end
            pcabs_pkg::OP_VERT: begin
                kind = pcabs_pkg::KIND_LINE;
                ey = a[0];
            end
            pcabs_pkg::OP_CUBIC: begin
                kind = pcabs_pkg::KIND_CUBIC;
                c1x = a[0];
                c1y = a[1];
                c2x = a[2];
                c2y = a[3];
                ex = a[4];
                ey = a[5];
            end
            pcabs_pkg::OP_SCUBIC: begin
                kind = pcabs_pkg::KIND_CUBIC;
                if (last_curve == pcabs_pkg::CURVE_CUBIC) begin
                    c1x = mirror(pos_x, ctl_x);
                    c1y = mirror(pos_y, ctl_y);
                end else begin
                    c1x = pos_x;
                    c1y = pos_y;
                end
                c2x = a[0];
                c2y = a[1];
                ex = a[2];
                ey = a[3];
            end
            pcabs_pkg::OP_QUAD: begin
                kind = pcabs_pkg::KIND_QUAD;
                c1x = a[0];
                c1y = a[1];
                ex = a[2];
                ey = a[3];
            end
            pcabs_pkg::OP_SQUAD: begin
                kind = pcabs_pkg::KIND_QUAD;
                if (last_curve == pcabs_pkg::CURVE_QUAD) begin
                    c1x = mirror(pos_x, ctl_x);
                    c1y = mirror(pos_y, ctl_y);
                end else begin
                    c1x = pos_x;
                    c1y = pos_y;
                end
                ex = a[0];
                ey = a[1];
            end
            pcabs_pkg::OP_CLOSE: begin
                kind = pcabs_pkg::KIND_CLOSE;
                ex = sub_x;
                ey = sub_y;
            end
            default: begin
                kind = pcabs_pkg::KIND_LINE;
                err_sticky = 1'b1;
            end
        endcase

        // Unknown opcodes leave pen, control and curve memory alone
        if (r.cmd.op <= pcabs_pkg::OP_CLOSE) begin
            pos_x = ex;
            pos_y = ey;
            if (kind == pcabs_pkg::KIND_CUBIC) begin
                ctl_x = c2x;
                ctl_y = c2y;
                last_curve = pcabs_pkg::CURVE_CUBIC;
            end else if (kind == pcabs_pkg::KIND_QUAD) begin
                ctl_x = c1x;
                ctl_y = c1y;
                last_curve = pcabs_pkg::CURVE_QUAD;
            end else begin
                ctl_x = ex;
                ctl_y = ey;
                last_curve = pcabs_pkg::CURVE_NONE;
            end
            if (kind == pcabs_pkg::KIND_MOVE) begin
                sub_x = ex;
                sub_y = ey;
            end
        end
        if (first && kind != pcabs_pkg::KIND_MOVE) err_sticky = 1'b1;

        res.kind = kind;
        res.ctrl1_x = pcabs_pkg::ARG_WIDTH'(c1x);
        res.ctrl1_y = pcabs_pkg::ARG_WIDTH'(c1y);
        res.ctrl2_x = pcabs_pkg::ARG_WIDTH'(c2x);
        res.ctrl2_y = pcabs_pkg::ARG_WIDTH'(c2y);
        res.end_x = pcabs_pkg::ARG_WIDTH'(ex);
        res.end_y = pcabs_pkg::ARG_WIDTH'(ey);
        res.path_error = err_sticky;
        return res;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned pick_idle();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 94) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Coordinate mix: extremes, full-range noise and plausible drawing values
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4: return $urandom;
            default: return 32'($urandom_range(32'h03FF_FFFF) - 32'h0200_0000);
        endcase
    endfunction

    task automatic add_req(input logic [pcabs_pkg::OP_WIDTH-1:0] op, input logic rel,
                           input logic rep, input logic fresh,
                           input logic [31:0] a0, input logic [31:0] a1,
                           input logic [31:0] a2, input logic [31:0] a3,
                           input logic [31:0] a4, input logic [31:0] a5);
        t_path_req r;
        r.cmd.op = op;
        r.cmd.relative = rel;
        r.cmd.repeat_group = rep;
        r.cmd.new_path = fresh;
        r.arg = {a5, a4, a3, a2, a1, a0};
        r.gap = send_busy ? pick_idle() : 0;
        r.drain = hold_next;
        hold_next = 1'b0;
        cmd_q.insert(cmd_q.size(), r);
    endtask

    task automatic add_random(input logic [pcabs_pkg::OP_WIDTH-1:0] op, input logic rel,
                              input logic rep, input logic fresh);
        add_req(op, rel, rep, fresh, pick_coord(), pick_coord(), pick_coord(),
                pick_coord(), pick_coord(), pick_coord());
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Driver: present queued requests, predict each one as it is taken
    always @(posedge i_clk) begin
        bit        taken;
        int        taken_now;
        t_path_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            taken = i_valid && !o_stall;
            taken_now = taken_cnt + (taken ? 1 : 0);
            if (taken) begin
                expected_abs_q.insert(expected_abs_q.size(), absolutize(on_bus));
                taken_cnt <= taken_now;
            end
            // Hold the payload while stalled; otherwise load the next request
            if (!i_valid || taken) begin
                if (cmd_q.size() != 0 && !gap_armed) begin
                    gap_left = cmd_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (cmd_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (cmd_q[0].drain && taken_now != done_cnt) begin
                    i_valid <= 1'b0;
                end else begin
                    nxt = cmd_q.pop_front();
                    on_bus = nxt;
                    gap_armed = 1'b0;
                    i_valid <= 1'b1;
                    i_op <= nxt.cmd.op;
                    i_relative <= nxt.cmd.relative;
                    i_repeat_group <= nxt.cmd.repeat_group;
                    i_new_path <= nxt.cmd.new_path;
                    i_arg0 <= nxt.arg[0];
                    i_arg1 <= nxt.arg[1];
                    i_arg2 <= nxt.arg[2];
                    i_arg3 <= nxt.arg[3];
                    i_arg4 <= nxt.arg[4];
                    i_arg5 <= nxt.arg[5];
                end
            end
        end
    end

    // Monitor: check taken results in order, stall the output at random
    always @(posedge i_clk) begin
        pcabs_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (done_cnt >= taken_cnt) begin
                    $error("result with no request outstanding: kind %0d", o_out_kind);
                    mismatch_cnt++;
                end else begin
                    want = expected_abs_q.pop_front();
                    check_field("out_kind", 32'(want.kind), 32'(o_out_kind));
                    check_field("ctrl1_x", want.ctrl1_x, o_ctrl1_x);
                    check_field("ctrl1_y", want.ctrl1_y, o_ctrl1_y);
                    check_field("ctrl2_x", want.ctrl2_x, o_ctrl2_x);
                    check_field("ctrl2_y", want.ctrl2_y, o_ctrl2_y);
                    check_field("end_x", want.end_x, o_end_x);
                    check_field("end_y", want.end_y, o_end_y);
                    check_field("path_error", 32'(want.path_error), 32'(o_path_error));
                    done_cnt <= done_cnt + 1;
                end
            end
            // Switch between stall-free stretches and random back-pressure
            stall_phase++;
            if (stall_phase % 256 == 0) recv_busy = ($urandom_range(2) != 0);
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (recv_busy) stall_left = pick_idle();
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int                             roll;
        int                             len;
        int                             k;
        logic [pcabs_pkg::OP_WIDTH-1:0] op;
        logic                           rep;

        // Directed: first request not a moveto, then a moveto with a repeat group
        add_req(pcabs_pkg::OP_LINE, 1'b0, 1'b0, 1'b0, Q_ONE, Q_ONE, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_MOVE, 1'b0, 1'b1, 1'b1, 2 * Q_ONE, 3 * Q_ONE, 0, 0, 0, 0);
        // Clean path at the coordinate extremes, saturating relative adds
        add_req(pcabs_pkg::OP_MOVE, 1'b0, 1'b0, 1'b1, Q_MAX, Q_MIN, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_LINE, 1'b1, 1'b0, 1'b0, Q_MAX, Q_MAX, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_HORIZ, 1'b1, 1'b0, 1'b0, Q_MIN, 0, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_VERT, 1'b0, 1'b0, 1'b0, Q_MAX, 0, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_CUBIC, 1'b1, 1'b0, 1'b0, Q_MIN, Q_MAX, Q_ONE, -Q_ONE,
                Q_MAX, Q_MIN);
        // Smooth cubics reflecting a cubic, then a smooth cubic
        add_req(pcabs_pkg::OP_SCUBIC, 1'b0, 1'b0, 1'b0, Q_ONE, Q_ONE, Q_MAX, Q_MIN, 0, 0);
        add_req(pcabs_pkg::OP_SCUBIC, 1'b1, 1'b0, 1'b0, -Q_ONE, Q_ONE, 5 * Q_ONE,
                -7 * Q_ONE, 0, 0);
        // Smooth quadratics after a quadratic, after themselves, after a line
        add_req(pcabs_pkg::OP_QUAD, 1'b0, 1'b0, 1'b0, Q_MIN, Q_MIN, 4 * Q_ONE, 4 * Q_ONE,
                0, 0);
        add_req(pcabs_pkg::OP_SQUAD, 1'b1, 1'b0, 1'b0, Q_ONE, -Q_ONE, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_SQUAD, 1'b0, 1'b0, 1'b0, Q_MAX, Q_MAX, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_LINE, 1'b0, 1'b0, 1'b0, 9 * Q_ONE, -9 * Q_ONE, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_SQUAD, 1'b0, 1'b0, 1'b0, Q_ONE, Q_ONE, 0, 0, 0, 0);
        // Smooth cubic after a quadratic takes the pen point
        add_req(pcabs_pkg::OP_QUAD, 1'b1, 1'b0, 1'b0, Q_ONE, Q_ONE, 2 * Q_ONE, 0, 0, 0);
        add_req(pcabs_pkg::OP_SCUBIC, 1'b0, 1'b0, 1'b0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE,
                4 * Q_ONE, 0, 0);
        add_req(pcabs_pkg::OP_CLOSE, 1'b1, 1'b1, 1'b0, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                Q_MAX, Q_MIN);
        add_req(pcabs_pkg::OP_MOVE, 1'b1, 1'b1, 1'b0, Q_ONE, -Q_ONE, 0, 0, 0, 0);
        // Unknown opcodes; curve memory survives them
        add_req(4'd9, 1'b0, 1'b0, 1'b0, Q_ONE, Q_ONE, 0, 0, 0, 0);
        add_req(4'd15, 1'b1, 1'b1, 1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_req(pcabs_pkg::OP_CUBIC, 1'b0, 1'b0, 1'b0, Q_ONE, 0, 2 * Q_ONE, Q_ONE,
                3 * Q_ONE, 3 * Q_ONE);
        add_req(4'd12, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_SCUBIC, 1'b0, 1'b0, 1'b0, 0, 0, Q_ONE, Q_ONE, 0, 0);
        // New path clears the error; close right after the moveto
        add_req(pcabs_pkg::OP_MOVE, 1'b1, 1'b0, 1'b1, Q_ONE, Q_ONE, 0, 0, 0, 0);
        add_req(pcabs_pkg::OP_CLOSE, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0);

        // Random: mostly well-formed paths, some broken starts and noise
        hold_next = 1'b1;
        while (cmd_q.size() < ITEM_COUNT) begin
            if (cmd_q.size() % 400 < 12) hold_next = 1'b1;
            send_busy = ($urandom_range(3) != 0);
            roll = int'($urandom_range(99));
            if (roll < 5) begin
                add_random(4'($urandom_range(15)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (roll < 10) begin
                add_random(4'($urandom_range(8)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'b1);
            end else begin
                add_random(pcabs_pkg::OP_MOVE, 1'($urandom_range(1)), 1'b0, 1'b1);
            end
            len = int'($urandom_range(14, 1));
            for (k = 0; k < len; k++) begin
                op = ($urandom_range(49) == 0) ? 4'($urandom_range(15, 9))
                                              : 4'($urandom_range(8));
                rep = (op == pcabs_pkg::OP_MOVE) ? ($urandom_range(9) < 7)
                                                 : 1'($urandom_range(1));
                add_random(op, 1'($urandom_range(1)), rep, 1'b0);
            end
        end
        items_total = cmd_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and answered, then settle
        while (taken_cnt != items_total || done_cnt != taken_cnt) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (expected_abs_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_abs_q.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
